/* hdl/cfe_pkg.sv */
// Shared types and constants of the comb filter energy unit.
package cfe_pkg;

  localparam int SAMPLE_BITS   = 16;
  localparam int PERIOD_BITS   = 12;
  localparam int COUNT_BITS    = 4;
  localparam int ENERGY_BITS   = 63;
  localparam int SEEN_BITS     = 24;
  localparam int APB_ADDR_BITS = 3;
  localparam int APB_DATA_BITS = 32;

  // register index, taken from paddr[2]
  localparam logic REG_PERIOD = 1'b0;
  localparam logic REG_COUNT  = 1'b1;

  localparam logic [ENERGY_BITS-1:0] ENERGY_MAX = '1;
  localparam logic [SEEN_BITS-1:0]   SEEN_MAX   = '1;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          band_end;
    logic                          group_end;
  } cfe_in_t;

  typedef struct packed {
    logic [ENERGY_BITS-1:0] energy;
    logic                   saturated;
  } cfe_out_t;

  typedef struct packed {
    logic push;
    logic clear;
  } cfe_acc_ctl_t;

  typedef struct packed {
    logic                   busy;
    logic                   saturated;
    logic [ENERGY_BITS-1:0] energy;
  } cfe_acc_sts_t;

endpackage

/* hdl/comb_filter_energy_unit.sv */
// Top level of the comb filter energy unit: history memories, sequencer, output register.
//
// Input channel (in_valid / in_stall / in_item): one signed band sample per item,
// with band_end and group_end flags. Both history memories are read in the cycle
// of acceptance, and the item is computed and written back in ST_CALC. The comb
// runs as a running sum:
//   y[j] = y[j-period] + x[j] - x[j-count*period]
// so each item needs one read of the comb memory and one of the sample memory.
// On band_end or group_end the tail of (count-1)*period outputs is flushed with
// zero input, each output through ST_TRD and ST_TCALC, with in_stall high meanwhile.
// Result channel (out_valid / out_stall / out_item): one item per group, the
// saturating sum of squares, once the squaring pipeline has drained after the
// last comb output. The result sits in an output register; while the
// receiver stalls, new samples are still taken, and only a further group end
// waits for the register to free up.
// Config (APB, pready tied high): period at 0x0, count at 0x4. in_stall is high
// during a write and in the cycle after it while derived spans settle.
// Reset (rst_n low, synchronous) clears counters, energy and config; history
// memories are not cleared and need no clearing pass.
module comb_filter_energy_unit
  import cfe_pkg::*;
#(
  parameter int MAX_PERIOD = 2048,
  parameter int MAX_PULSES = 8
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  cfe_in_t                  in_item,
  output logic                     out_valid,
  input  logic                     out_stall,
  output cfe_out_t                 out_item,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [APB_ADDR_BITS-1:0] paddr,
  input  logic [APB_DATA_BITS-1:0] pwdata,
  output logic [APB_DATA_BITS-1:0] prdata,
  output logic                     pready
);

  localparam int AW  = $clog2(MAX_PULSES * MAX_PERIOD);     // sample memory address
  localparam int CAW = $clog2(MAX_PERIOD);                  // comb memory address
  localparam int PW  = $clog2(MAX_PERIOD + 1);
  localparam int NW  = $clog2(MAX_PULSES + 1);
  localparam int SW  = $clog2(MAX_PULSES * MAX_PERIOD + 1);
  localparam int YW  = SAMPLE_BITS + $clog2(MAX_PULSES) + 1;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_CALC  = 3'd1;  // sample item: compute and write back
  localparam logic [2:0] ST_TRD   = 3'd2;  // tail: memory read cycle
  localparam logic [2:0] ST_TCALC = 3'd3;  // tail: compute and write back
  localparam logic [2:0] ST_DRAIN = 3'd4;  // wait for squarer, then emit

  // ---- configuration ----
  logic [PERIOD_BITS-1:0] cfg_period_r;
  logic [COUNT_BITS-1:0]  cfg_count_r;
  logic                   cfg_settle_r;
  logic                   cfg_wr;
  logic                   reg_idx;

  logic [31:0]            per_sel;
  logic [31:0]            cnt_sel;
  logic [PW-1:0]          per_eff;
  logic [NW-1:0]          cnt_eff;
  logic [SW-1:0]          span_nxt;

  // derived values, registered
  logic [PW-1:0]          per_q_r;
  logic [SW-1:0]          span_r;   // count * period
  logic [SW-1:0]          tail_r;   // (count - 1) * period

  // ---- sequencer ----
  logic [2:0]             state_r, state_nxt;
  logic [SEEN_BITS-1:0]   j_r, j_nxt;       // position within the band, tail included
  logic [SEEN_BITS-1:0]   j_inc;
  logic [SW-1:0]          m_r, m_nxt;       // tail step
  logic [AW-1:0]          tpos_r, tpos_nxt; // ring position
  logic                   out_valid_r, out_valid_nxt;
  logic                   out_load;
  logic                   in_accept;
  logic                   calc_any;
  logic                   band_done;
  cfe_in_t                item_r;
  cfe_out_t               out_item_r;

  // ---- memories ----
  logic signed [SAMPLE_BITS-1:0] samp_mem [2**AW];
  logic signed [YW-1:0]          comb_mem [2**CAW];
  logic signed [SAMPLE_BITS-1:0] samp_rd_r;
  logic signed [YW-1:0]          comb_rd_r;
  logic [AW-1:0]                 samp_raddr;
  logic [CAW-1:0]                comb_raddr;

  // ---- datapath ----
  logic                   comb_ok;
  logic                   samp_ok;
  logic signed [YW-1:0]   comb_term;
  logic signed [YW-1:0]   x_term;
  logic signed [YW-1:0]   old_term;
  logic signed [YW-1:0]   y_val;

  cfe_acc_ctl_t           acc_ctl;
  cfe_acc_sts_t           acc_sts;

  // APB
  assign cfg_wr  = psel && penable && pwrite;
  assign reg_idx = paddr[2];
  assign pready  = 1'b1;

  always_comb begin
    unique case (reg_idx)
      REG_PERIOD: prdata = APB_DATA_BITS'(cfg_period_r);
      REG_COUNT:  prdata = APB_DATA_BITS'(cfg_count_r);
      default:    prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_period_r <= PERIOD_BITS'(1);
      cfg_count_r  <= COUNT_BITS'(1);
      cfg_settle_r <= 1'b0;
    end else begin
      cfg_settle_r <= cfg_wr;
      if (cfg_wr) begin
        unique case (reg_idx)
          REG_PERIOD: cfg_period_r <= pwdata[PERIOD_BITS-1:0];
          REG_COUNT:  cfg_count_r  <= pwdata[COUNT_BITS-1:0];
          default:    ;
        endcase
      end
    end
  end

  // zero acts as one, values above the maximum are clamped
  always_comb begin
    per_sel = 32'(cfg_period_r);
    if (per_sel == 32'd0) per_sel = 32'd1;
    else if (per_sel > 32'(MAX_PERIOD)) per_sel = 32'(MAX_PERIOD);
    cnt_sel = 32'(cfg_count_r);
    if (cnt_sel == 32'd0) cnt_sel = 32'd1;
    else if (cnt_sel > 32'(MAX_PULSES)) cnt_sel = 32'(MAX_PULSES);
    per_eff  = PW'(per_sel);
    cnt_eff  = NW'(cnt_sel);
    span_nxt = SW'(cnt_eff) * SW'(per_eff);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      per_q_r <= PW'(1);
      span_r  <= SW'(1);
      tail_r  <= '0;
    end else begin
      per_q_r <= per_eff;
      span_r  <= span_nxt;
      tail_r  <= span_nxt - SW'(per_eff);
    end
  end

  // Handshake. Stall while busy, during reset and around config writes.
  assign in_stall  = !rst_n || (state_r != ST_IDLE) || cfg_settle_r || cfg_wr;
  assign in_accept = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // Reads are issued every cycle for the current ring position; the data is
  // ready in the cycle after acceptance or after a tail read cycle.
  assign samp_raddr = tpos_r - span_r[AW-1:0];
  assign comb_raddr = tpos_r[CAW-1:0] - per_q_r[CAW-1:0];

  always_ff @(posedge clk) begin
    if (state_r == ST_CALC) samp_mem[tpos_r] <= item_r.sample;
    samp_rd_r <= samp_mem[samp_raddr];
  end

  always_ff @(posedge clk) begin
    if (calc_any) comb_mem[tpos_r[CAW-1:0]] <= y_val;
    comb_rd_r <= comb_mem[comb_raddr];
  end

  // Running sum; terms that fall before the band start count as zero.
  assign calc_any  = (state_r == ST_CALC) || (state_r == ST_TCALC);
  assign band_done = item_r.band_end || item_r.group_end;
  assign j_inc     = (j_r == SEEN_MAX) ? j_r : j_r + SEEN_BITS'(1);

  always_comb begin
    comb_ok   = j_r >= SEEN_BITS'(per_q_r);
    samp_ok   = j_r >= SEEN_BITS'(span_r);
    comb_term = comb_ok ? comb_rd_r : '0;
    x_term    = (state_r == ST_CALC) ? YW'(item_r.sample) : '0;
    old_term  = samp_ok ? YW'(samp_rd_r) : '0;
    y_val     = comb_term + x_term - old_term;
  end

  always_comb begin
    state_nxt     = state_r;
    j_nxt         = j_r;
    m_nxt         = m_r;
    tpos_nxt      = tpos_r;
    out_valid_nxt = out_valid_r;
    out_load      = 1'b0;
    acc_ctl.push  = calc_any;
    acc_ctl.clear = 1'b0;
    if (out_valid_r && !out_stall) out_valid_nxt = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_accept) state_nxt = ST_CALC;
      end
      ST_CALC: begin
        tpos_nxt = tpos_r + AW'(1);
        j_nxt    = j_inc;
        if (band_done) begin
          if (tail_r != '0) begin
            m_nxt     = '0;
            state_nxt = ST_TRD;
          end else begin
            j_nxt     = '0;
            state_nxt = item_r.group_end ? ST_DRAIN : ST_IDLE;
          end
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_TRD: begin
        state_nxt = ST_TCALC;
      end
      ST_TCALC: begin
        tpos_nxt = tpos_r + AW'(1);
        j_nxt    = j_inc;
        if (m_r == tail_r - SW'(1)) begin
          j_nxt     = '0;
          state_nxt = item_r.group_end ? ST_DRAIN : ST_IDLE;
        end else begin
          m_nxt     = m_r + SW'(1);
          state_nxt = ST_TRD;
        end
      end
      ST_DRAIN: begin
        if (!acc_sts.busy && (!out_valid_r || !out_stall)) begin
          out_load      = 1'b1;
          out_valid_nxt = 1'b1;
          acc_ctl.clear = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      j_r         <= '0;
      m_r         <= '0;
      tpos_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      j_r         <= j_nxt;
      m_r         <= m_nxt;
      tpos_r      <= tpos_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) item_r <= in_item;
    if (out_load) begin
      out_item_r.energy    <= acc_sts.energy;
      out_item_r.saturated <= acc_sts.saturated;
    end
  end

  cfe_energy_acc #(
    .YW (YW)
  ) u_acc (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (acc_ctl),
    .y     (y_val),
    .sts   (acc_sts)
  );

endmodule

/* hdl/cfe_energy_acc.sv */
// Square and saturating sum of comb outputs, three register stages.
module cfe_energy_acc
  import cfe_pkg::*;
#(
  parameter int YW = 20
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  cfe_acc_ctl_t         ctl,
  input  logic signed [YW-1:0] y,
  output cfe_acc_sts_t         sts
);

  localparam int MX = (YW > 33) ? YW : 33;
  localparam int MW = (YW < 32) ? YW : 32;

  logic signed [YW-1:0]     y_r;
  logic                     v1_r;
  logic [2*MW-1:0]          sq_r;
  logic                     big_r;
  logic                     v2_r;
  logic [ENERGY_BITS-1:0]   energy_r;
  logic                     sat_r;

  logic [YW-1:0]            mag;
  logic [MX-1:0]            mag_x;
  logic [MW-1:0]            mag_lo;
  logic [ENERGY_BITS+1:0]   sum;
  logic                     over;

  always_comb begin
    mag    = y_r[YW-1] ? YW'(-y_r) : YW'(y_r);
    mag_x  = MX'(mag);
    mag_lo = mag_x[MW-1:0];
    sum    = (ENERGY_BITS+2)'(energy_r) + (ENERGY_BITS+2)'(sq_r);
    over   = big_r || (sum[ENERGY_BITS+1:ENERGY_BITS] != 2'b00);
  end

  always_ff @(posedge clk) begin
    y_r  <= y;
    sq_r <= (2*MW)'(mag_lo) * (2*MW)'(mag_lo);
    big_r <= |mag_x[MX-1:32];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r     <= 1'b0;
      v2_r     <= 1'b0;
      energy_r <= '0;
      sat_r    <= 1'b0;
    end else begin
      v1_r <= ctl.push;
      v2_r <= v1_r;
      if (ctl.clear) begin
        energy_r <= '0;
        sat_r    <= 1'b0;
      end else if (v2_r) begin
        if (over) begin
          energy_r <= ENERGY_MAX;
          sat_r    <= 1'b1;
        end else begin
          energy_r <= sum[ENERGY_BITS-1:0];
        end
      end
    end
  end

  assign sts.busy      = v1_r | v2_r;
  assign sts.saturated = sat_r;
  assign sts.energy    = energy_r;

endmodule

/* hdl/cfe_port_checker.sv */
// Port-level assertions for the comb filter energy unit, with bind.
module cfe_port_checker
  import cfe_pkg::*;
(
  input logic                     clk,
  input logic                     rst_n,
  input logic                     in_valid,
  input logic                     in_stall,
  input cfe_in_t                  in_item,
  input logic                     out_valid,
  input logic                     out_stall,
  input cfe_out_t                 out_item,
  input logic                     psel,
  input logic                     penable,
  input logic                     pwrite,
  input logic [APB_ADDR_BITS-1:0] paddr,
  input logic [APB_DATA_BITS-1:0] pwdata,
  input logic [APB_DATA_BITS-1:0] prdata,
  input logic                     pready
);

  // no result right after reset
  a_reset_out: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out_valid high after reset");

  // each item is computed before the next one is taken
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("item accepted in back-to-back cycles");

  // the input stalls while derived spans settle after a register write
  a_cfg_settle: assert property (@(posedge clk) disable iff (!rst_n)
    psel && penable && pwrite && pready |=> in_stall)
    else $error("item accepted right after a config write");

  // a saturated sum is pinned at its ceiling
  a_sat_ceiling: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.saturated |-> out_item.energy == ENERGY_MAX)
    else $error("saturated result below ceiling");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("stalled result changed");

endmodule

bind comb_filter_energy_unit cfe_port_checker u_port_checker (.*);

/* tb/tb.sv */
// Self-checking testbench for comb_filter_energy_unit: directed table, then random phases.
module tb;
  import cfe_pkg::*;

  // Block sizing; the predictor history is as deep as the longest comb reach.
  localparam int MAX_PERIOD   = 2048;
  localparam int MAX_PULSES   = 8;
  localparam int HIST_DEPTH   = (MAX_PULSES - 1) * MAX_PERIOD + 1;
  localparam int CYCLE_LIMIT  = 2_000_000;
  // Output register trails the last tail output by a short squaring pipeline.
  localparam int DRAIN_CYCLES = 16;
  // Config writes keep in_stall high in the cycle after them; leave some slack.
  localparam int CFG_SETTLE   = 8;
  localparam int ITEM_TARGET  = 1000;
  localparam int GROUP_TARGET = 60;
  localparam int N_ROWS       = 26;
  localparam logic [63:0] SUM_CEIL = {1'b0, ENERGY_MAX};

  typedef enum logic {ROW_CFG, ROW_ITEM} row_kind_e;

  // One line of the directed table: a config setting or an item, with an
  // optional hand-written expected result for the easy cases.
  typedef struct packed {
    row_kind_e                     kind;
    logic [PERIOD_BITS-1:0]        period;
    logic [COUNT_BITS-1:0]         count;
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          band_end;
    logic                          group_end;
    logic                          typed;
    logic [ENERGY_BITS-1:0]        energy;
    logic                          saturated;
  } stim_row_t;

  // ---------------------------------------------------------------------------
  // Clock, DUT and its ports
  // ---------------------------------------------------------------------------
  logic                     clk = 1'b0;
  logic                     rst_n;
  logic                     in_valid;
  logic                     in_stall;
  cfe_in_t                  in_item;
  logic                     out_valid;
  logic                     out_stall;
  cfe_out_t                 out_item;
  logic                     psel;
  logic                     penable;
  logic                     pwrite;
  logic [APB_ADDR_BITS-1:0] paddr;
  logic [APB_DATA_BITS-1:0] pwdata;
  logic [APB_DATA_BITS-1:0] prdata;
  logic                     pready;

  always #6 clk = ~clk;

  comb_filter_energy_unit u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  // ---------------------------------------------------------------------------
  // Predictor: direct comb sum over a sample ring, saturating sum of squares
  // ---------------------------------------------------------------------------
  shortint                comb_hist [HIST_DEPTH];
  int unsigned            hist_wr      = 0;
  int unsigned            band_len     = 0;
  logic [63:0]            group_energy = '0;
  bit                     group_sat    = 1'b0;
  logic [PERIOD_BITS-1:0] period_reg   = 1;
  logic [COUNT_BITS-1:0]  count_reg    = 1;

  cfe_out_t    energy_due [$];
  int          fail_count  = 0;
  int unsigned items_sent  = 0;
  int unsigned groups_sent = 0;
  int unsigned cycle_count = 0;
  bit          calm_phase  = 1'b0;  // no gaps and no stalls on either side
  cfe_out_t    due_head;

  // Sample that lies 'back' items before the newest one.
  function automatic longint hist_back(int unsigned back);
    return longint'(comb_hist[(hist_wr + HIST_DEPTH - 1 - back % HIST_DEPTH) % HIST_DEPTH]);
  endfunction

  // One comb output. In the tail, m counts flushed zero inputs; taps that
  // would land before the band start contribute nothing.
  function automatic longint comb_output(int unsigned per, int unsigned cnt,
                                         int unsigned n, int unsigned m, bit in_tail);
    longint      y;
    int unsigned d;
    y = 0;
    for (int unsigned k = 0; k < cnt; k++) begin
      d = k * per;
      if (!in_tail) begin
        if (d < n) y += hist_back(d);
      end else if (d > m && d - m <= n) begin
        y += hist_back(d - m - 1);
      end
    end
    return y;
  endfunction

  // Overflow pins the sum at the ceiling; with 16-bit samples a run of this
  // length cannot get there, but the rule is kept.
  function automatic void add_square(longint y);
    logic [63:0] mag;
    logic [63:0] sq;
    mag = y;
    if (y < 0) mag = -y;
    if (mag > 64'hFFFF_FFFF) begin
      group_energy = SUM_CEIL;
      group_sat    = 1'b1;
    end else begin
      sq = mag * mag;
      if (sq > SUM_CEIL - group_energy) begin
        group_energy = SUM_CEIL;
        group_sat    = 1'b1;
      end else begin
        group_energy += sq;
      end
    end
  endfunction

  function automatic void comb_energy_predict(input cfe_in_t it, output bit emits,
                                              output cfe_out_t res);
    int unsigned per;
    int unsigned cnt;
    int unsigned tail;
    // zero acts as one, anything past the hardware maximum is clamped
    per = (period_reg == 0) ? 1 : period_reg;
    if (per > MAX_PERIOD) per = MAX_PERIOD;
    cnt = (count_reg == 0) ? 1 : count_reg;
    if (cnt > MAX_PULSES) cnt = MAX_PULSES;

    comb_hist[hist_wr] = it.sample;
    hist_wr = (hist_wr + 1) % HIST_DEPTH;
    if (band_len < SEEN_MAX) band_len++;
    add_square(comb_output(per, cnt, band_len, 0, 1'b0));

    // group end closes the band too, so the tail goes in before the emit
    if (it.band_end || it.group_end) begin
      tail = (cnt - 1) * per;
      for (int unsigned m = 0; m < tail; m++)
        add_square(comb_output(per, cnt, band_len, m, 1'b1));
      band_len = 0;
    end

    emits         = it.group_end;
    res.energy    = group_energy[ENERGY_BITS-1:0];
    res.saturated = group_sat;
    if (emits) begin
      group_energy = '0;
      group_sat    = 1'b0;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------
  task automatic send_item(input cfe_in_t it, input bit typed, input cfe_out_t typed_res);
    int unsigned gap;
    bit          emits;
    cfe_out_t    res;
    gap = calm_phase ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk); while (in_stall);
    comb_energy_predict(it, emits, res);
    if (emits) begin
      energy_due.push_back(typed ? typed_res : res);
      groups_sent++;
    end
    items_sent++;
  endtask

  // Drop valid and let every pending result come out before touching config.
  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (energy_due.size() != 0) @(posedge clk);
    repeat (CFG_SETTLE) @(negedge clk);
  endtask

  task automatic write_reg(input logic [APB_ADDR_BITS-1:0] addr,
                           input logic [APB_DATA_BITS-1:0] data);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (addr[2] == REG_PERIOD) period_reg = data[PERIOD_BITS-1:0];
    else                       count_reg  = data[COUNT_BITS-1:0];
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Upper data bits carry junk; the registers keep only their own width.
  task automatic set_comb(input logic [PERIOD_BITS-1:0] per,
                          input logic [COUNT_BITS-1:0] cnt);
    logic [APB_DATA_BITS-1:0] junk;
    wait_idle();
    junk = $urandom();
    write_reg({REG_PERIOD, 2'b00}, {junk[APB_DATA_BITS-1:PERIOD_BITS], per});
    junk = $urandom();
    write_reg({REG_COUNT, 2'b00}, {junk[APB_DATA_BITS-1:COUNT_BITS], cnt});
  endtask

  // ---------------------------------------------------------------------------
  // Result side: random stall before each result, then wait for it
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned hold;
    out_stall = 1'b1;
    forever begin
      hold = calm_phase ? 0 : $urandom_range(0, 16);
      if (hold > 0) begin
        @(negedge clk);
        out_stall <= 1'b1;
        repeat (hold - 1) @(negedge clk);
      end
      @(negedge clk);
      out_stall <= 1'b0;
      do @(posedge clk); while (!(rst_n && out_valid));
    end
  end

  // Compare every accepted result with the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (energy_due.size() == 0) begin
        $error("result with nothing expected: energy=%0d saturated=%0b",
               out_item.energy, out_item.saturated);
        fail_count++;
      end else begin
        due_head = energy_due.pop_front();
        if (out_item.energy !== due_head.energy) begin
          $error("energy: expected %0d, got %0d", due_head.energy, out_item.energy);
          fail_count++;
        end
        if (out_item.saturated !== due_head.saturated) begin
          $error("saturated: expected %0b, got %0b", due_head.saturated, out_item.saturated);
          fail_count++;
        end
      end
    end
  end

  // Watchdog: long tail flushes are budgeted in, a hang is not.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin
    stim_row_t              rows [N_ROWS];
    cfe_in_t                it;
    cfe_out_t               typed_res;
    logic [PERIOD_BITS-1:0] per;
    logic [COUNT_BITS-1:0]  cnt;
    int unsigned            n_groups;
    int unsigned            max_bands;
    int unsigned            max_len;
    int unsigned            n_bands;
    int unsigned            len;

    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_item  = '0;
    psel     = 1'b0;
    penable  = 1'b0;
    pwrite   = 1'b0;
    paddr    = '0;
    pwdata   = '0;

    // Directed table. Reset config is period 1, count 1, so each output is
    // the sample itself and the first results can be written by hand.
    rows = '{
      '{ROW_ITEM, 12'd0,    4'd0,  16'sh8000,   1'b0, 1'b1, 1'b1, 63'd1073741824, 1'b0},
      '{ROW_ITEM, 12'd0,    4'd0,  16'sh7FFF,   1'b0, 1'b1, 1'b1, 63'd1073676289, 1'b0},
      '{ROW_ITEM, 12'd0,    4'd0,  16'sd0,      1'b1, 1'b1, 1'b1, 63'd0,          1'b0},
      '{ROW_ITEM, 12'd0,    4'd0,  16'sd1,      1'b1, 1'b0, 1'b0, 63'd0,          1'b0},
      '{ROW_ITEM, 12'd0,    4'd0,  16'sd2,      1'b0, 1'b1, 1'b1, 63'd5,          1'b0},
      // zero period acts as one; short band then group end without band end
      '{ROW_CFG,  12'd0,    4'd3,  16'sd0,      1'b0, 1'b0, 1'b0, 63'd0,          1'b0},
      '{ROW_ITEM, 12'd0,    4'd0,  16'sd100,    1'b0, 1'b0, 1'b0, 63'd0,          1'b0},
      '{ROW_ITEM, 12'd0,    4'd0,  16'sd200,    1'b1, 1'b0, 1'b0, 63'd0,          1'b0},
      '{ROW_ITEM, 12'd0,    4'd0,  -16'sd300,   1'b0, 1'b1, 1'b0, 63'd0,          1'b0},
      // long period clamps to the maximum; two samples, full-length tail
      '{ROW_CFG,  12'd4095, 4'd2,  16'sd0,      1'b0, 1'b0, 1'b0, 63'd0,          1'b0},
      '{ROW_ITEM, 12'd0,    4'd0,  16'sd5,      1'b0, 1'b0, 1'b0, 63'd0,          1'b0},
      '{ROW_ITEM, 12'd0,    4'd0,  -16'sd7,     1'b1, 1'b1, 1'b0, 63'd0,          1'b0},
      // zero pulses acts as one pulse: no tail, output is the sample
      '{ROW_CFG,  12'd3,    4'd0,  16'sd0,      1'b0, 1'b0, 1'b0, 63'd0,          1'b0},
      '{ROW_ITEM, 12'd0,    4'd0,  16'sh7FFF,   1'b0, 1'b0, 1'b0, 63'd0,          1'b0},
      '{ROW_ITEM, 12'd0,    4'd0,  16'sh8000,   1'b1, 1'b1, 1'b1, 63'd2147418113, 1'b0},
      // too many pulses clamps to the maximum; extremes pile up in the comb
      '{ROW_CFG,  12'd2,    4'd15, 16'sd0,      1'b0, 1'b0, 1'b0, 63'd0,          1'b0},
      '{ROW_ITEM, 12'd0,    4'd0,  16'sh7FFF,   1'b0, 1'b0, 1'b0, 63'd0,          1'b0},
      '{ROW_ITEM, 12'd0,    4'd0,  16'sh7FFF,   1'b0, 1'b0, 1'b0, 63'd0,          1'b0},
      '{ROW_ITEM, 12'd0,    4'd0,  16'sh8000,   1'b0, 1'b0, 1'b0, 63'd0,          1'b0},
      '{ROW_ITEM, 12'd0,    4'd0,  16'sh7FFF,   1'b0, 1'b0, 1'b0, 63'd0,          1'b0},
      '{ROW_ITEM, 12'd0,    4'd0,  16'sh7FFF,   1'b0, 1'b0, 1'b0, 63'd0,          1'b0},
      '{ROW_ITEM, 12'd0,    4'd0,  16'sd12345,  1'b0, 1'b1, 1'b0, 63'd0,          1'b0},
      // period one, eight pulses: every tap on adjacent samples
      '{ROW_CFG,  12'd1,    4'd8,  16'sd0,      1'b0, 1'b0, 1'b0, 63'd0,          1'b0},
      '{ROW_ITEM, 12'd0,    4'd0,  16'sh8000,   1'b0, 1'b0, 1'b0, 63'd0,          1'b0},
      '{ROW_ITEM, 12'd0,    4'd0,  16'sh8000,   1'b0, 1'b0, 1'b0, 63'd0,          1'b0},
      '{ROW_ITEM, 12'd0,    4'd0,  16'sh8000,   1'b1, 1'b1, 1'b0, 63'd0,          1'b0}
    };

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (rows[i]) begin
      if (rows[i].kind == ROW_CFG) begin
        set_comb(rows[i].period, rows[i].count);
      end else begin
        it.sample              = rows[i].sample;
        it.band_end            = rows[i].band_end;
        it.group_end           = rows[i].group_end;
        typed_res.energy       = rows[i].energy;
        typed_res.saturated    = rows[i].saturated;
        send_item(it, rows[i].typed, typed_res);
      end
    end

    // Random phases. Each phase picks a comb setting and sends whole groups,
    // the last item of a phase always closing a group so the block is idle
    // before the next config write. Long combs are rare and get one short
    // band only: their tail of (count-1)*period outputs is long to flush.
    while (items_sent < ITEM_TARGET || groups_sent < GROUP_TARGET) begin
      calm_phase = ($urandom_range(0, 3) == 0);
      case ($urandom_range(0, 9))
        0: begin
          case ($urandom_range(0, 2))
            0:       per = 12'd4095;
            1:       per = MAX_PERIOD;
            default: per = $urandom_range(1024, 4095);
          endcase
          case ($urandom_range(0, 2))
            0:       cnt = 4'd15;
            1:       cnt = MAX_PULSES;
            default: cnt = $urandom_range(2, 15);
          endcase
          n_groups  = 1;
          max_bands = 1;
          max_len   = 30;
        end
        1: begin
          per       = $urandom_range(0, 4095);
          cnt       = $urandom_range(0, 3);
          n_groups  = 1;
          max_bands = 1;
          max_len   = 12;
        end
        default: begin
          per       = $urandom_range(0, 12);
          cnt       = $urandom_range(0, 15);
          n_groups  = $urandom_range(1, 4);
          max_bands = 3;
          max_len   = 12;
        end
      endcase
      set_comb(per, cnt);

      for (int unsigned g = 0; g < n_groups; g++) begin
        n_bands = $urandom_range(1, max_bands);
        for (int unsigned b = 0; b < n_bands; b++) begin
          len = $urandom_range(1, max_len);
          for (int unsigned s = 0; s < len; s++) begin
            // bias toward the rails so sums get large
            case ($urandom_range(0, 7))
              0:       it.sample = 16'sh8000;
              1:       it.sample = 16'sh7FFF;
              2:       it.sample = '0;
              default: it.sample = $urandom();
            endcase
            it.group_end = (s == len - 1) && (b == n_bands - 1);
            // last band may end on group_end alone
            it.band_end  = (s == len - 1) &&
                           (b != n_bands - 1 || $urandom_range(0, 1) == 1);
            send_item(it, 1'b0, '0);
          end
        end
      end
    end

    // Drain: every group's result out, then a wait of DRAIN_CYCLES for strays.
    @(negedge clk);
    in_valid <= 1'b0;
    while (energy_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

/* sim.f */
hdl/cfe_pkg.sv
hdl/cfe_energy_acc.sv
hdl/comb_filter_energy_unit.sv
hdl/cfe_port_checker.sv
tb/tb.sv
